/* hw/rtl/vn_pkg.sv */
// ----------------------------------------------------------------------------
// vn_pkg
// Shared types and fixed constants of the vector normalizer: field widths,
// the length register reset value and the controller-to-datapath commands.
// ----------------------------------------------------------------------------
package vn_pkg;

  // fixed widths of the result fields and of the length register
  localparam int UNIT_W      = 16;
  localparam int MAG_OUT_W   = 19;
  localparam int LEN_REG_W   = 7;
  localparam int FRAC_SHIFT  = 14;

  localparam logic [LEN_REG_W-1:0] LEN_RESET = 7'd64;

  // commands from the controller to the datapath
  typedef struct packed {
    logic elem_wr;    // store element, latch its size
    logic sq_mul;     // square the latched size
    logic sq_acc;     // add the square to the running sum
    logic sum_clr;    // drop the partial sum
    logic root_init;  // load the sum into the root unit, clear the sum
    logic root_step;  // one root iteration
    logic mem_rd;     // read one stored element
    logic div_init;   // load dividend and divisor
    logic div_step;   // one quotient bit
  } vn_cmd_t;

endpackage

/* hw/rtl/vn_datapath.sv */
// ----------------------------------------------------------------------------
// vn_datapath
// Element store, sum of squares, iterative square root (two radicand bits a
// step) and restoring divider (one quotient bit a step).
// ----------------------------------------------------------------------------
module vn_datapath
  import vn_pkg::*;
#(
  parameter int ELEMENT_WIDTH = 16,
  parameter int MAX_LENGTH    = 64,
  parameter int ADDR_W        = 6,
  parameter int SUM_W         = 37,
  parameter int MAG_W         = 19,
  parameter int QUO_W         = 15
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  vn_cmd_t                         cmd_i,
  input  logic [ADDR_W-1:0]               wr_addr_i,
  input  logic [ADDR_W-1:0]               rd_addr_i,
  input  logic signed [ELEMENT_WIDTH-1:0] element_value_i,
  output logic signed [UNIT_W-1:0]        unit_value_o,
  output logic [MAG_OUT_W-1:0]            vector_magnitude_o,
  output logic                            zero_vector_o
);

  localparam int EW     = ELEMENT_WIDTH;
  localparam int PROD_W = 2 * EW;
  localparam int DV_W   = MAG_W + QUO_W;

  function automatic logic [EW-1:0] size_of(input logic [EW-1:0] x);
    return x[EW-1] ? (~x + 1'b1) : x;
  endfunction

  logic [EW-1:0]      mem_q [MAX_LENGTH];
  logic [EW-1:0]      rdata_q;
  logic [EW-1:0]      size_q;
  logic [PROD_W-1:0]  prod_q;
  logic [SUM_W-1:0]   sum_q;
  logic [SUM_W-1:0]   rad_q;
  logic [SUM_W-1:0]   root_q;
  logic [SUM_W-1:0]   bit_q;
  logic [SUM_W:0]     trial;
  logic [DV_W-1:0]    rem_q;
  logic [DV_W-1:0]    dsr_q;
  logic [QUO_W-1:0]   quo_q;
  logic               neg_q;
  logic [MAG_W-1:0]   mag;
  logic [UNIT_W-1:0]  quo_cut;

  // element store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.elem_wr) begin
      mem_q[wr_addr_i] <= element_value_i;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // element size and its square
  always_ff @(posedge clk_i) begin
    if (cmd_i.elem_wr) begin
      size_q <= size_of(element_value_i);
    end
    if (cmd_i.sq_mul) begin
      prod_q <= PROD_W'(size_q) * PROD_W'(size_q);
    end
  end

  // running sum of squares
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (cmd_i.sum_clr || cmd_i.root_init) begin
      sum_q <= '0;
    end else if (cmd_i.sq_acc) begin
      sum_q <= sum_q + SUM_W'(prod_q);
    end
  end

  // square root, one result bit per step
  assign trial = {1'b0, root_q} + {1'b0, bit_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_init) begin
      rad_q  <= sum_q;
      root_q <= '0;
      bit_q  <= SUM_W'(1) << (2 * (MAG_W - 1));
    end else if (cmd_i.root_step) begin
      if ({1'b0, rad_q} >= trial) begin
        rad_q  <= rad_q - trial[SUM_W-1:0];
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign mag = root_q[MAG_W-1:0];

  // restoring divider, quotient bit per step, divisor walks right
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      neg_q <= rdata_q[EW-1];
      rem_q <= DV_W'({size_of(rdata_q), {FRAC_SHIFT{1'b0}}});
      dsr_q <= DV_W'(mag) << (QUO_W - 1);
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_q >= dsr_q) begin
        rem_q <= rem_q - dsr_q;
        quo_q <= {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[QUO_W-2:0], 1'b0};
      end
      dsr_q <= dsr_q >> 1;
    end
  end

  // result word
  assign quo_cut            = UNIT_W'(quo_q);
  assign zero_vector_o      = (root_q == '0);
  assign vector_magnitude_o = MAG_OUT_W'(mag);
  assign unit_value_o       = zero_vector_o ? '0 :
                              (neg_q ? (~quo_cut + 1'b1) : quo_cut);

endmodule

/* hw/rtl/vn_controller.sv */
// ----------------------------------------------------------------------------
// vn_controller
// Sequencer of the vector normalizer: element loading, root iterations and
// the per-element divide and emit loop. Holds the length register.
// ----------------------------------------------------------------------------
module vn_controller
  import vn_pkg::*;
#(
  parameter int MAX_LENGTH = 64,
  parameter int ADDR_W     = 6,
  parameter int CNT_W      = 7,
  parameter int MAG_W      = 19,
  parameter int QUO_W      = 15
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 cfg_we_i,
  input  logic [LEN_REG_W-1:0] cfg_wdata_i,
  output vn_cmd_t              cmd_o,
  output logic [ADDR_W-1:0]    wr_addr_o,
  output logic [ADDR_W-1:0]    rd_addr_o,
  output logic                 strobe_o,
  output logic                 last_element_o
);

  localparam int STEP_MAX = (MAG_W > QUO_W) ? MAG_W : QUO_W;
  localparam int STEP_W   = $clog2(STEP_MAX + 1);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_MUL       = 4'd1;
  localparam logic [3:0] S_ACC       = 4'd2;
  localparam logic [3:0] S_ROOT_INIT = 4'd3;
  localparam logic [3:0] S_ROOT      = 4'd4;
  localparam logic [3:0] S_READ      = 4'd5;
  localparam logic [3:0] S_LOAD      = 4'd6;
  localparam logic [3:0] S_DIV       = 4'd7;
  localparam logic [3:0] S_EMIT      = 4'd8;

  logic [3:0]           state_q, state_d;
  logic [LEN_REG_W-1:0] len_q, len_d;
  logic [CNT_W-1:0]     loaded_q, loaded_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic [STEP_W-1:0]    step_q, step_d;
  logic [31:0]          len_ext;
  logic [CNT_W-1:0]     eff_len;
  logic [CNT_W:0]       loaded_nx;
  logic [CNT_W:0]       idx_nx;
  logic                 is_last;

  // effective length: zero acts as one, clamp at the store depth
  assign len_ext = 32'(len_q);
  assign eff_len = (len_q == '0) ? CNT_W'(1) :
                   (len_ext > MAX_LENGTH) ? CNT_W'(MAX_LENGTH) : CNT_W'(len_ext);

  assign loaded_nx = {1'b0, loaded_q} + 1'b1;
  assign idx_nx    = {1'b0, idx_q} + 1'b1;
  assign is_last   = (idx_nx == {1'b0, eff_len});

  assign wr_addr_o      = loaded_q[ADDR_W-1:0];
  assign rd_addr_o      = idx_q[ADDR_W-1:0];
  assign busy           = (state_q != S_IDLE);
  assign strobe_o       = (state_q == S_EMIT);
  assign last_element_o = strobe_o && is_last;

  // next state and commands
  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    loaded_d = loaded_q;
    idx_d    = idx_q;
    step_d   = step_q;
    cmd_o    = '0;

    if (cfg_we_i) begin
      len_d         = cfg_wdata_i;
      loaded_d      = '0;
      cmd_o.sum_clr = 1'b1;
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.elem_wr = 1'b1;
          state_d       = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.sq_mul = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        cmd_o.sq_acc = 1'b1;
        if (loaded_nx >= {1'b0, eff_len}) begin
          loaded_d = '0;
          state_d  = S_ROOT_INIT;
        end else begin
          loaded_d = loaded_nx[CNT_W-1:0];
          state_d  = S_IDLE;
        end
      end
      S_ROOT_INIT: begin
        cmd_o.root_init = 1'b1;
        step_d          = '0;
        state_d         = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.root_step = 1'b1;
        step_d          = step_q + 1'b1;
        if (step_q == STEP_W'(MAG_W - 1)) begin
          idx_d   = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.div_init = 1'b1;
        step_d         = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == STEP_W'(QUO_W - 1)) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (is_last) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d   = idx_nx[CNT_W-1:0];
          state_d = S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      len_q    <= LEN_RESET;
      loaded_q <= '0;
      idx_q    <= '0;
      step_q   <= '0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      loaded_q <= loaded_d;
      idx_q    <= idx_d;
      step_q   <= step_d;
    end
  end

  // checks
  a_last_with_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_element_o |-> strobe_o)
    else $error("last mark without a result word");

  a_idle_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_element_o |=> !busy)
    else $error("still busy after the final word of a vector");

  a_partial_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> (loaded_q < eff_len))
    else $error("partial vector count reached the vector length");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not start work");

  a_emit_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (idx_q < eff_len))
    else $error("emit index past vector length");

endmodule

/* hw/rtl/vector_normalizer.sv */
// ----------------------------------------------------------------------------
// vector_normalizer
// Buffers signed fixed-point vector elements, takes the Euclidean length
// by integer square root of the sum of squares and emits each element
// divided by that length.
//
// channel   direction  handshake           payload
// -------   ---------  ------------------  --------------------------------
// element   in         start / busy        element_value_i
// result    out        strobe_o            unit_value_o, vector_magnitude_o,
//                                          zero_vector_o, last_element_o
// config    in         cfg_we_i            cfg_wdata_i (vector length)
//
// An element that does not complete its vector keeps busy high through the
// square state and then the accumulate state.
// The completing element then runs the root (one load, then the root
// iterations), then for each result word one store read, one divider load,
// the divide steps with one quotient bit per step, and one emit.
// Reset clears the control state and the sum; the element store is not
// cleared, only entries of the current vector are read.
// Result words are shown for one cycle each; the receiver cannot stall.
// ----------------------------------------------------------------------------
module vector_normalizer
  import vn_pkg::*;
#(
  parameter int MAX_LENGTH    = 64,
  parameter int ELEMENT_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [ELEMENT_WIDTH-1:0] element_value_i,
  input  logic                            cfg_we_i,
  input  logic [LEN_REG_W-1:0]            cfg_wdata_i,
  output logic                            strobe_o,
  output logic signed [UNIT_W-1:0]        unit_value_o,
  output logic [MAG_OUT_W-1:0]            vector_magnitude_o,
  output logic                            zero_vector_o,
  output logic                            last_element_o
);

  localparam int ADDR_W     = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int CNT_W      = $clog2(MAX_LENGTH + 1);
  localparam int SUM_FULL_W = 2 * ELEMENT_WIDTH - 1 + $clog2(MAX_LENGTH);
  localparam int SUM_W      = (SUM_FULL_W > 64) ? 64 : SUM_FULL_W;
  localparam int MAG_W      = (SUM_W + 1) / 2;
  // a wrapped sum no longer bounds the quotient, then all bits are needed
  localparam int QUO_W      = (SUM_FULL_W > 64) ? (ELEMENT_WIDTH + FRAC_SHIFT)
                                                : (FRAC_SHIFT + 1);

  vn_cmd_t           cmd;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  // sequencer
  vn_controller #(
    .MAX_LENGTH (MAX_LENGTH),
    .ADDR_W     (ADDR_W),
    .CNT_W      (CNT_W),
    .MAG_W      (MAG_W),
    .QUO_W      (QUO_W)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_o          (cmd),
    .wr_addr_o      (wr_addr),
    .rd_addr_o      (rd_addr),
    .strobe_o       (strobe_o),
    .last_element_o (last_element_o)
  );

  // arithmetic and element store
  vn_datapath #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH),
    .MAX_LENGTH    (MAX_LENGTH),
    .ADDR_W        (ADDR_W),
    .SUM_W         (SUM_W),
    .MAG_W         (MAG_W),
    .QUO_W         (QUO_W)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .wr_addr_i          (wr_addr),
    .rd_addr_i          (rd_addr),
    .element_value_i    (element_value_i),
    .unit_value_o       (unit_value_o),
    .vector_magnitude_o (vector_magnitude_o),
    .zero_vector_o      (zero_vector_o)
  );

endmodule

/* bench/vector_normalizer_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector_normalizer_test
// Self-checking bench for the vector normalizer. Elements are sent in bursts
// with random gaps, and a model inside the bench predicts every result word.
// A monitor compares each strobed word with the oldest prediction. Directed
// vectors cover the field extremes, zero vectors, the length register limits
// and the discard of a partly loaded vector. Random phases then follow with
// mixed lengths and mixed element content.
// ----------------------------------------------------------------------------
module vector_normalizer_test;
  import vn_pkg::*;

  localparam int MAX_LEN     = 64;
  localparam int ITEM_TARGET = 330;
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 400000;

  // one predicted result word
  typedef struct packed {
    logic signed [UNIT_W-1:0] unit_val;
    logic [MAG_OUT_W-1:0]     mag;
    logic                     zero;
    logic                     last;
  } norm_word_t;

  logic                     clk_i           = 1'b0;
  logic                     rst_ni          = 1'b0;
  logic                     start           = 1'b0;
  logic                     busy;
  logic signed [15:0]       element_value_i = '0;
  logic                     cfg_we_i        = 1'b0;
  logic [LEN_REG_W-1:0]     cfg_wdata_i     = '0;
  logic                     strobe_o;
  logic signed [UNIT_W-1:0] unit_value_o;
  logic [MAG_OUT_W-1:0]     vector_magnitude_o;
  logic                     zero_vector_o;
  logic                     last_element_o;

  // bench copy of the block state
  logic signed [15:0]   held_elems [MAX_LEN];
  int                   held_count   = 0;
  logic [63:0]          square_total = '0;
  logic [LEN_REG_W-1:0] length_reg   = LEN_RESET;

  norm_word_t pending_words [$];
  norm_word_t want_word;
  int         error_count = 0;
  int         sent_count  = 0;
  int         cycle_count = 0;
  int         burst_left  = 0;
  bit         steady      = 0;

  vector_normalizer u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .element_value_i    (element_value_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .strobe_o           (strobe_o),
    .unit_value_o       (unit_value_o),
    .vector_magnitude_o (vector_magnitude_o),
    .zero_vector_o      (zero_vector_o),
    .last_element_o     (last_element_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // elements per vector as the block applies the register
  function automatic int active_length(logic [LEN_REG_W-1:0] reg_val);
    if (reg_val == 0) return 1;
    if (reg_val > MAX_LEN) return MAX_LEN;
    return int'(reg_val);
  endfunction

  // floor of the square root, one result bit per pass
  function automatic logic [63:0] floor_root(logic [63:0] value);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] b;
    rem = value;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // size of a signed element
  function automatic logic [63:0] elem_size(logic signed [15:0] v);
    int x;
    x = int'(v);
    if (x < 0) x = -x;
    return 64'(x);
  endfunction

  // store an accepted element; on the completing one queue the unit words
  task automatic absorb_element(input logic signed [15:0] v);
    int          slot;
    int          len;
    logic [63:0] mag;
    logic [63:0] q;
    logic [63:0] q_neg;
    norm_word_t  w;
    slot = (held_count >= MAX_LEN) ? MAX_LEN - 1 : held_count;
    held_elems[slot] = v;
    square_total = square_total + elem_size(v) * elem_size(v);
    held_count = slot + 1;
    len = active_length(length_reg);
    if (held_count >= len) begin
      mag = floor_root(square_total);
      for (int i = 0; i < len; i++) begin
        w.unit_val = '0;
        if (mag != 0) begin
          q     = (elem_size(held_elems[i]) << FRAC_SHIFT) / mag;
          q_neg = ~q + 64'd1;
          w.unit_val = held_elems[i][15] ? q_neg[UNIT_W-1:0] : q[UNIT_W-1:0];
        end
        w.mag  = mag[MAG_OUT_W-1:0];
        w.zero = (mag == 0);
        w.last = (i + 1 == len);
        pending_words.push_back(w);
      end
      held_count   = 0;
      square_total = '0;
    end
  endtask

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      if (pending_words.size() == 0) begin
        $error("result word with none expected");
        error_count++;
      end else begin
        want_word = pending_words.pop_front();
        if (unit_value_o !== want_word.unit_val) begin
          $error("unit_value expected %0d actual %0d", want_word.unit_val, unit_value_o);
          error_count++;
        end
        if (vector_magnitude_o !== want_word.mag) begin
          $error("vector_magnitude expected %0d actual %0d", want_word.mag,
                 vector_magnitude_o);
          error_count++;
        end
        if (zero_vector_o !== want_word.zero) begin
          $error("zero_vector expected %0d actual %0d", want_word.zero, zero_vector_o);
          error_count++;
        end
        if (last_element_o !== want_word.last) begin
          $error("last_element expected %0d actual %0d", want_word.last, last_element_o);
          error_count++;
        end
      end
    end
  end

  // send one word; start stays high after the task returns, until release_start lowers it
  task automatic send_element(input logic signed [15:0] v);
    @(negedge clk_i);
    start           = 1'b1;
    element_value_i = v;
    do @(posedge clk_i); while (busy);
    absorb_element(v);
    sent_count++;
  endtask

  task automatic release_start();
    if (start) begin
      @(negedge clk_i);
      start           = 1'b0;
      element_value_i = 16'($urandom);
    end
  endtask

  task automatic idle_gap(input int n);
    release_start();
    repeat (n) @(negedge clk_i);
  endtask

  // send within the burst pattern of the sender
  task automatic push_element(input logic signed [15:0] v);
    send_element(v);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if (!steady) idle_gap($urandom_range(1, 12));
    end
  endtask

  // wait until every predicted word is out and the block is idle
  task automatic wait_idle();
    release_start();
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // length register write, also drops any partial vector
  task automatic write_length(input logic [LEN_REG_W-1:0] v);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    length_reg   = v;
    held_count   = 0;
    square_total = '0;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cfg_wdata_i = LEN_REG_W'($urandom);
  endtask

  // element content by mode
  function automatic logic signed [15:0] pick_element(input int mode, input bit hot);
    logic [15:0] r;
    r = 16'($urandom);
    case (mode)
      0: return '0;
      1: begin
        case ($urandom_range(0, 3))
          0: return -16'sd32768;
          1: return 16'sd32767;
          2: return -16'sd32767;
          default: return '0;
        endcase
      end
      2: return hot ? $signed(r) : 16'sd0;
      3, 4: return 16'($signed($urandom_range(0, 32)) - 16);
      default: return $signed(r);
    endcase
  endfunction

  // reset length, one full vector of random words
  task automatic test_reset_length();
    logic [15:0] r;
    for (int i = 0; i < MAX_LEN; i++) begin
      r = 16'($urandom);
      push_element($signed(r));
    end
  endtask

  // single-element vectors at the field extremes and the zero vector
  task automatic test_single_element();
    write_length(7'd1);
    send_element(16'sd32767);
    send_element(-16'sd32768);
    send_element(16'sd0);
    send_element(16'sd1);
    send_element(-16'sd1);
  endtask

  // a length of zero acts as one
  task automatic test_length_zero();
    write_length(7'd0);
    send_element(16'sh1234);
    send_element(-16'sd5);
  endtask

  // two-element vectors
  task automatic test_pairs();
    write_length(7'd2);
    send_element(-16'sd32768);
    send_element(-16'sd32768);
    send_element(16'sd32767);
    send_element(-16'sd32768);
    send_element(16'sd0);
    send_element(16'sd0);
    send_element(16'sd3);
    send_element(-16'sd4);
  endtask

  // a register write drops the partly loaded vector
  task automatic test_discard();
    write_length(7'd5);
    send_element(16'sd1000);
    send_element(-16'sd2000);
    send_element(16'sd3000);
    write_length(7'd3);
    send_element(16'sd300);
    send_element(16'sd400);
    send_element(-16'sd1200);
  endtask

  // random phases of length, content and pacing
  task automatic test_random_vectors();
    logic [LEN_REG_W-1:0] len_val;
    int                   len;
    int                   mode;
    int                   hot_idx;
    int                   sel;
    bit                   first_phase;
    first_phase = 1;
    while (sent_count < ITEM_TARGET) begin
      sel = $urandom_range(0, 19);
      if (first_phase) len_val = 7'd127;
      else if (sel == 0) len_val = 7'd0;
      else if (sel == 1) len_val = 7'd64;
      else if (sel == 2) len_val = 7'($urandom_range(65, 127));
      else if (sel <= 4) len_val = 7'($urandom_range(9, 63));
      else len_val = 7'($urandom_range(1, 8));
      first_phase = 0;
      write_length(len_val);
      len    = active_length(len_val);
      steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 4)) begin
        if (sent_count >= ITEM_TARGET) break;
        mode    = $urandom_range(0, 9);
        hot_idx = $urandom_range(0, len - 1);
        for (int i = 0; i < len; i++) push_element(pick_element(mode, i == hot_idx));
        // hold off until the vector has drained
        if ($urandom_range(0, 5) == 0) wait_idle();
      end
      // broken vector left for the next register write to drop
      if (sent_count < ITEM_TARGET && len > 1 && $urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, len - 1)) push_element(pick_element(9, 1'b0));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_length();
    test_single_element();
    test_length_zero();
    test_pairs();
    test_discard();
    test_random_vectors();
    wait_idle();
    repeat (40) @(posedge clk_i);
    if (error_count == 0 && pending_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
